// ----- hw/rtl/auto_exposure_pid_step_macros.svh -----
// Assertion macros shared by the auto-exposure PID checker.
`ifndef AUTO_EXPOSURE_PID_STEP_MACROS_SVH
`define AUTO_EXPOSURE_PID_STEP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define AEPID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define AEPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define AEPID_ASSERT_NEXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/aepid_pkg.sv -----
// Shared widths, register indexes and reset values of the auto-exposure PID step.
package aepid_pkg;

    localparam int INTENS_W   = 16;
    localparam int EXPO_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int ERR_W      = INTENS_W + 1;
    localparam int DELTA_W    = INTENS_W + 2;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_BITS  = 24;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int PD_W  = GAIN_W + DELTA_W;
    localparam int ACC_W = PI_W + 2;
    localparam int UPD_W = ACC_W - FRAC_BITS;
    localparam int RES_W = UPD_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd6;

    localparam logic [INTENS_W-1:0] TARGET_RESET  = 16'h8000;
    localparam logic [EXPO_W-1:0]   EXPO_MAX      = 24'hFF_FFFF;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

endpackage

// ----- hw/rtl/aepid_in_if.sv -----
// Input channel: measured intensity and current exposure per frame.
interface aepid_in_if;
    logic                             valid;
    logic                             ready;
    logic [aepid_pkg::INTENS_W-1:0]   measured_intensity;
    logic [aepid_pkg::EXPO_W-1:0]     current_exposure;

    modport source (output valid, output measured_intensity, output current_exposure,
                    input ready);
    modport sink   (input valid, input measured_intensity, input current_exposure,
                    output ready);
endinterface

// ----- hw/rtl/aepid_out_if.sv -----
// Output channel: next exposure and saturation flag.
interface aepid_out_if;
    logic                         valid;
    logic                         ready;
    logic [aepid_pkg::EXPO_W-1:0] new_exposure;
    logic                         was_constrained;

    modport source (output valid, output new_exposure, output was_constrained,
                    input ready);
    modport sink   (input valid, input new_exposure, input was_constrained,
                    output ready);
endinterface

// ----- hw/rtl/auto_exposure_pid_step.sv -----
// Auto-exposure PID step: four-stage pipeline with saturating integral and output clamp.
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+-------------
//  i_in     | in  | measured_intensity, current_exposure  | valid/ready
//  o_out    | out | new_exposure, was_constrained         | valid/ready
//  i_cfg_*  | in  | register index, write data            | write enable
//
// Registers: stage 1, 2, 3, output; one transaction per cycle while o_out is not stalled.
// Stage 1 takes the error, integral and delta (state updates at accept),
// stage 2 the three gain multiplies, stage 3 the sum and rounding,
// stage 4 the saturation test and clamp into the output register.
// Synchronous active-low reset clears integral, last error and valids, and resets config.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
module auto_exposure_pid_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    aepid_in_if.sink                            i_in,
    aepid_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [aepid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aepid_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // configuration registers
    logic        [aepid_pkg::INTENS_W-1:0] r_target;
    logic signed [aepid_pkg::GAIN_W-1:0]   r_prop_gain;
    logic signed [aepid_pkg::GAIN_W-1:0]   r_integ_gain;
    logic signed [aepid_pkg::GAIN_W-1:0]   r_deriv_gain;
    logic        [aepid_pkg::EXPO_W-1:0]   r_floor;
    logic        [aepid_pkg::EXPO_W-1:0]   r_dev_max;
    logic        [aepid_pkg::EXPO_W-1:0]   r_ceiling;

    // controller state
    logic signed [aepid_pkg::SUM_W-1:0]    r_error_sum;
    logic signed [aepid_pkg::ERR_W-1:0]    r_prev_err;

    // pipeline valids and per-stage load enables
    logic r_v1, r_v2, r_v3, r_ov;
    logic rdy1, rdy2, rdy3, rdy_o;

    // stage 1
    logic signed [aepid_pkg::ERR_W-1:0]    r_s1_err;
    logic signed [aepid_pkg::SUM_W-1:0]    r_s1_sum;
    logic signed [aepid_pkg::DELTA_W-1:0]  r_s1_delta;
    logic        [aepid_pkg::EXPO_W-1:0]   r_s1_expo;

    // stage 2
    logic signed [aepid_pkg::PP_W-1:0]     r_s2_pp;
    logic signed [aepid_pkg::PI_W-1:0]     r_s2_pi;
    logic signed [aepid_pkg::PD_W-1:0]     r_s2_pd;
    logic        [aepid_pkg::EXPO_W-1:0]   r_s2_expo;
    logic                                  r_s2_neg, r_s2_pos;

    // stage 3
    logic signed [aepid_pkg::UPD_W-1:0]    r_s3_upd;
    logic        [aepid_pkg::EXPO_W-1:0]   r_s3_expo;
    logic                                  r_s3_neg, r_s3_pos;

    // output register
    logic [aepid_pkg::EXPO_W-1:0]          r_o_expo;
    logic                                  r_o_con;

    // combinational intermediates
    logic signed [aepid_pkg::ERR_W-1:0]    err;
    logic signed [aepid_pkg::SUM_W:0]      sum_wide;
    logic signed [aepid_pkg::SUM_W-1:0]    n_error_sum;
    logic signed [aepid_pkg::DELTA_W-1:0]  delta;
    logic signed [aepid_pkg::ACC_W-1:0]    acc;
    logic signed [aepid_pkg::RES_W-1:0]    res;
    logic signed [aepid_pkg::RES_W-1:0]    res_lo;
    logic signed [aepid_pkg::RES_W-1:0]    res_hi;
    logic        [aepid_pkg::EXPO_W-1:0]   clamped;
    logic                                  constrained;
    logic        [aepid_pkg::EXPO_W-1:0]   n_o_expo;

    assign rdy_o = !r_ov || o_out.ready;
    assign rdy3  = !r_v3 || rdy_o;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;

    assign i_in.ready            = rdy1;
    assign o_out.valid           = r_ov;
    assign o_out.new_exposure    = r_o_expo;
    assign o_out.was_constrained = r_o_con;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= aepid_pkg::TARGET_RESET;
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_floor      <= '0;
            r_dev_max    <= aepid_pkg::EXPO_MAX;
            r_ceiling    <= aepid_pkg::EXPO_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aepid_pkg::REG_TARGET:     r_target     <= i_cfg_wdata[aepid_pkg::INTENS_W-1:0];
                aepid_pkg::REG_PROP_GAIN:  r_prop_gain  <= $signed(i_cfg_wdata);
                aepid_pkg::REG_INTEG_GAIN: r_integ_gain <= $signed(i_cfg_wdata);
                aepid_pkg::REG_DERIV_GAIN: r_deriv_gain <= $signed(i_cfg_wdata);
                aepid_pkg::REG_FLOOR:      r_floor      <= i_cfg_wdata;
                aepid_pkg::REG_DEV_MAX:    r_dev_max    <= i_cfg_wdata;
                aepid_pkg::REG_CEILING:    r_ceiling    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // error, saturating integral and delta at the input transaction
    always_comb begin
        err = $signed({1'b0, r_target}) - $signed({1'b0, i_in.measured_intensity});
        sum_wide = $signed({r_error_sum[aepid_pkg::SUM_W-1], r_error_sum})
                 + $signed({{(aepid_pkg::SUM_W + 1 - aepid_pkg::ERR_W){err[aepid_pkg::ERR_W-1]}},
                            err});
        if (sum_wide[aepid_pkg::SUM_W] != sum_wide[aepid_pkg::SUM_W-1]) begin
            n_error_sum = sum_wide[aepid_pkg::SUM_W] ? aepid_pkg::SUM_MIN : aepid_pkg::SUM_MAX;
        end else begin
            n_error_sum = sum_wide[aepid_pkg::SUM_W-1:0];
        end
        delta = $signed({err[aepid_pkg::ERR_W-1], err})
              - $signed({r_prev_err[aepid_pkg::ERR_W-1], r_prev_err});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_prev_err  <= '0;
            r_v1        <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_in.valid;
            if (i_in.valid) begin
                r_error_sum <= n_error_sum;
                r_prev_err  <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r_s1_err   <= err;
            r_s1_sum   <= n_error_sum;
            r_s1_delta <= delta;
            r_s1_expo  <= i_in.current_exposure;
        end
    end

    // stage 2: gain products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_s2_pp   <= aepid_pkg::PP_W'(r_prop_gain * r_s1_err);
            r_s2_pi   <= aepid_pkg::PI_W'(r_integ_gain * r_s1_sum);
            r_s2_pd   <= aepid_pkg::PD_W'(r_deriv_gain * r_s1_delta);
            r_s2_expo <= r_s1_expo;
            r_s2_neg  <= r_s1_err[aepid_pkg::ERR_W-1];
            r_s2_pos  <= !r_s1_err[aepid_pkg::ERR_W-1] && (r_s1_err != '0);
        end
    end

    // stage 3: exact sum, round half up, drop fraction
    always_comb begin
        acc = aepid_pkg::ACC_W'(r_s2_pp) + aepid_pkg::ACC_W'(r_s2_pi)
            + aepid_pkg::ACC_W'(r_s2_pd)
            + $signed({{(aepid_pkg::ACC_W - aepid_pkg::FRAC_BITS){1'b0}},
                       1'b1, {(aepid_pkg::FRAC_BITS - 1){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_s3_upd  <= acc[aepid_pkg::ACC_W-1:aepid_pkg::FRAC_BITS];
            r_s3_expo <= r_s2_expo;
            r_s3_neg  <= r_s2_neg;
            r_s3_pos  <= r_s2_pos;
        end
    end

    // stage 4: saturation test and clamp; ceiling is tested before floor
    always_comb begin
        res    = aepid_pkg::RES_W'(r_s3_upd)
               + $signed({{(aepid_pkg::RES_W - aepid_pkg::EXPO_W){1'b0}}, r_s3_expo});
        res_lo = $signed({{(aepid_pkg::RES_W - aepid_pkg::EXPO_W){1'b0}}, r_floor});
        res_hi = $signed({{(aepid_pkg::RES_W - aepid_pkg::EXPO_W){1'b0}}, r_ceiling});
        if (res > res_hi) begin
            clamped = r_ceiling;
        end else if (res < res_lo) begin
            clamped = r_floor;
        end else begin
            clamped = res[aepid_pkg::EXPO_W-1:0];
        end
        // crossed bounds: the clamped value is always the ceiling
        if (r_floor > r_ceiling) begin
            clamped = r_ceiling;
        end
        constrained = (r_s3_neg && (r_s3_expo <= r_floor))
                   || (r_s3_pos && (r_s3_expo >= r_dev_max));
        if (constrained) begin
            n_o_expo = r_s3_pos ? r_ceiling : r_floor;
        end else begin
            n_o_expo = clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && r_v3) begin
            r_o_expo <= n_o_expo;
            r_o_con  <= constrained;
        end
    end

endmodule

// ----- hw/rtl/aepid_checker.sv -----
// Port-level checker for the auto-exposure PID step, bound to auto_exposure_pid_step.
`include "auto_exposure_pid_step_macros.svh"

module aepid_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [aepid_pkg::EXPO_W-1:0]      i_new_exposure,
    input logic                              i_was_constrained
);

    // a stalled result keeps its transaction
    `AEPID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_new_exposure) && $stable(i_was_constrained),
        "output transaction changed while stalled")

    // reset empties the pipeline
    `AEPID_ASSERT_NEXT_RST(a_rst_clear, i_clk, !i_rst_n, !i_out_valid,
        "output valid after reset")

    // with the output register empty nothing can back up to the input
    `AEPID_ASSERT_NOW(a_in_free, i_clk, i_rst_n, !i_out_valid, i_in_ready,
        "input stalled while output register empty")

    // with no input transaction in flight, no result can surface at the output
    `AEPID_ASSERT_NEXT(a_no_shortcut, i_clk, i_rst_n,
        !i_out_valid && !$past(i_in_valid && i_in_ready) && !(i_in_valid && i_in_ready)
            && !$past(i_out_valid) && $past(i_in_ready) && i_in_ready && !$past(i_in_valid)
            && $past(i_in_ready, 2) && !$past(i_in_valid, 2) && !$past(i_out_valid, 2)
            && $past(i_rst_n, 3) && !$past(i_in_valid, 3) && $past(i_in_ready, 3),
        !i_out_valid,
        "result appeared with no transaction in flight")

endmodule

bind auto_exposure_pid_step aepid_checker u_aepid_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_new_exposure    (o_out.new_exposure),
    .i_was_constrained (o_out.was_constrained)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the auto-exposure PID step: driver, monitor, predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTENS_W   = aepid_pkg::INTENS_W;
    localparam int EXPO_W     = aepid_pkg::EXPO_W;
    localparam int GAIN_W     = aepid_pkg::GAIN_W;
    localparam int ERR_W      = aepid_pkg::ERR_W;
    localparam int SUM_W      = aepid_pkg::SUM_W;
    localparam int CFG_IDX_W  = aepid_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = aepid_pkg::CFG_DATA_W;
    localparam int FRAC_BITS  = aepid_pkg::FRAC_BITS;

    localparam int PIPE_LAT = 4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES_PRE  = 8;
    localparam int RANDOM_PHASES_POST = 4;
    localparam int FRAMES_PER_PHASE   = 60;

    typedef struct packed {
        logic [INTENS_W-1:0] meas;
        logic [EXPO_W-1:0]   expo;
    } t_frame;

    typedef struct packed {
        logic [EXPO_W-1:0] expo;
        logic              hit;
    } t_exposure;

    typedef struct {
        logic [INTENS_W-1:0]      target;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [EXPO_W-1:0]        lo;
        logic [EXPO_W-1:0]        dmax;
        logic [EXPO_W-1:0]        hi;
    } t_settings;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_RUNS} t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    aepid_in_if  in_ch();
    aepid_out_if out_ch();

    auto_exposure_pid_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Register mirror and controller state
    logic [INTENS_W-1:0]      tgt_r;
    logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
    logic [EXPO_W-1:0]        lo_r, dmax_r, hi_r;
    logic signed [SUM_W-1:0]  integ_acc = '0;
    logic signed [ERR_W-1:0]  last_err = '0;

    t_frame    frame_q[$];
    t_exposure exposure_q[$];

    bit       drv_busy;
    int       frames_sent;
    int       burst_left = 1;
    int       gap_left;
    t_frame   drv_frame;
    t_rx_mode rx_mode;
    int       mode_left;
    int       run_left;
    bit       run_level;
    bit       rdy_next;

    int mismatches;
    int frames_in;
    int results_out;
    int bound_hits;
    int settings_loaded;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results outstanding", exposure_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_mismatch(string what, longint want, longint got);
        if (mismatches < 50)
            $display("MISMATCH %s: expected %0h got %0h (result %0d)",
                     what, want, got, results_out);
        mismatches++;
    endtask

    // One controller step; advances the integral and last error.
    function automatic t_exposure next_exposure(t_frame f);
        longint    err, sum, delta, acc, upd, res;
        bit        hit;
        t_exposure r;
        err = longint'(tgt_r) - longint'(f.meas);
        sum = longint'(integ_acc) + err;
        if (sum > longint'(aepid_pkg::SUM_MAX)) sum = longint'(aepid_pkg::SUM_MAX);
        if (sum < longint'(aepid_pkg::SUM_MIN)) sum = longint'(aepid_pkg::SUM_MIN);
        integ_acc = sum[SUM_W-1:0];
        delta = err - longint'(last_err);
        last_err = err[ERR_W-1:0];
        acc = longint'(kp_r) * err + longint'(ki_r) * sum + longint'(kd_r) * delta;
        upd = (acc + 64'sd8388608) >>> FRAC_BITS;
        hit = (err < 0 && longint'(f.expo) <= longint'(lo_r)) ||
              (err > 0 && longint'(f.expo) >= longint'(dmax_r));
        if (hit) begin
            res = (err > 0) ? longint'(hi_r) : longint'(lo_r);
        end else begin
            res = longint'(f.expo) + upd;
            if (res < longint'(lo_r)) res = longint'(lo_r);
            if (res > longint'(hi_r)) res = longint'(hi_r);
        end
        r.expo = res[EXPO_W-1:0];
        r.hit  = hit;
        return r;
    endfunction

    // Sender: bursts of frames with random gaps
    always @(negedge i_clk) begin
        // the monitor has counted the transaction on the held frame
        if (drv_busy && frames_in == frames_sent) begin
            drv_busy = 1'b0;
        end
        if (i_rst_n && !drv_busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (frame_q.size() > 0) begin
                drv_frame = frame_q.pop_front();
                in_ch.measured_intensity <= drv_frame.meas;
                in_ch.current_exposure   <= drv_frame.expo;
                drv_busy = 1'b1;
                frames_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        in_ch.valid <= drv_busy;
    end

    // Receiver: stall pattern switches between open, sparse and long runs
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 200);
        end else begin
            mode_left--;
        end
        if (run_left == 0) begin
            run_level = ~run_level;
            run_left = $urandom_range(1, 10);
        end else begin
            run_left--;
        end
        case (rx_mode)
            RX_OPEN:   rdy_next = 1'b1;
            RX_SPARSE: rdy_next = ($urandom_range(0, 3) != 0);
            default:   rdy_next = run_level;
        endcase
        out_ch.ready <= rdy_next;
    end

    // Monitor: check results, predict on each accepted frame
    always @(posedge i_clk) begin
        t_exposure want;
        t_frame    f;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (exposure_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", 0, out_ch.new_exposure);
                end else begin
                    want = exposure_q.pop_front();
                    if (out_ch.new_exposure !== want.expo)
                        flag_mismatch("new_exposure", want.expo, out_ch.new_exposure);
                    if (out_ch.was_constrained !== want.hit)
                        flag_mismatch("was_constrained", want.hit, out_ch.was_constrained);
                    if (want.hit) bound_hits++;
                end
                results_out++;
            end
            if (in_ch.valid && in_ch.ready) begin
                f.meas = in_ch.measured_intensity;
                f.expo = in_ch.current_exposure;
                exposure_q.push_back(next_exposure(f));
                frames_in++;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            aepid_pkg::REG_TARGET:     tgt_r  = data[INTENS_W-1:0];
            aepid_pkg::REG_PROP_GAIN:  kp_r   = data;
            aepid_pkg::REG_INTEG_GAIN: ki_r   = data;
            aepid_pkg::REG_DERIV_GAIN: kd_r   = data;
            aepid_pkg::REG_FLOOR:      lo_r   = data;
            aepid_pkg::REG_DEV_MAX:    dmax_r = data;
            aepid_pkg::REG_CEILING:    hi_r   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(t_settings s);
        // target gets random upper bits, which the register drops
        write_reg(aepid_pkg::REG_TARGET, {(CFG_DATA_W - INTENS_W)'($urandom), s.target});
        write_reg(aepid_pkg::REG_PROP_GAIN, s.kp);
        write_reg(aepid_pkg::REG_INTEG_GAIN, s.ki);
        write_reg(aepid_pkg::REG_DERIV_GAIN, s.kd);
        write_reg(aepid_pkg::REG_FLOOR, s.lo);
        write_reg(aepid_pkg::REG_DEV_MAX, s.dmax);
        write_reg(aepid_pkg::REG_CEILING, s.hi);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        settings_loaded++;
    endtask

    // Wait until every pending frame has produced its result
    task automatic drain();
        while (frame_q.size() != 0 || drv_busy || exposure_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic add_frame(logic [INTENS_W-1:0] m, logic [EXPO_W-1:0] x);
        frame_q.push_back('{meas: m, expo: x});
    endtask

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return {1'b1, {(GAIN_W-1){1'b0}}};
            1:       return {1'b0, {(GAIN_W-1){1'b1}}};
            2:       return '0;
            3, 4:    return GAIN_W'($urandom_range(0, 262143)) - GAIN_W'(131072);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [EXPO_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return aepid_pkg::EXPO_MAX;
            2:       return EXPO_W'($urandom_range(0, 4095));
            default: return EXPO_W'($urandom);
        endcase
    endfunction

    function automatic t_settings random_settings();
        t_settings         s;
        logic [EXPO_W-1:0] a, b, c, t;
        case ($urandom_range(0, 3))
            0:       s.target = '0;
            1:       s.target = '1;
            2:       s.target = aepid_pkg::TARGET_RESET;
            default: s.target = INTENS_W'($urandom);
        endcase
        s.kp = pick_gain();
        s.ki = pick_gain();
        s.kd = pick_gain();
        a = pick_level();
        b = pick_level();
        c = pick_level();
        // mostly floor <= ceiling <= device max; otherwise left unordered
        if ($urandom_range(0, 2) != 0) begin
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
        end
        s.lo   = a;
        s.hi   = b;
        s.dmax = c;
        return s;
    endfunction

    task automatic add_random_frame();
        logic [INTENS_W-1:0] m;
        logic [EXPO_W-1:0]   x;
        case ($urandom_range(0, 5))
            0:       m = tgt_r;
            1:       m = tgt_r + INTENS_W'($urandom_range(0, 32)) - INTENS_W'(16);
            2:       m = '0;
            3:       m = '1;
            default: m = INTENS_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       x = lo_r;
            1:       x = $urandom_range(0, 1) ? lo_r + 1'b1 : lo_r - 1'b1;
            2:       x = dmax_r;
            3:       x = $urandom_range(0, 1) ? dmax_r + 1'b1 : dmax_r - 1'b1;
            4:       x = hi_r;
            5:       x = $urandom_range(0, 1) ? '0 : aepid_pkg::EXPO_MAX;
            default: x = EXPO_W'($urandom);
        endcase
        add_frame(m, x);
    endtask

    task automatic run_random_phases(int phases);
        repeat (phases) begin
            load_settings(random_settings());
            repeat (FRAMES_PER_PHASE) add_random_frame();
            drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = aepid_pkg::REG_TARGET;
        i_cfg_wdata = '0;
        tgt_r  = aepid_pkg::TARGET_RESET;
        kp_r   = '0;
        ki_r   = '0;
        kd_r   = '0;
        lo_r   = '0;
        dmax_r = aepid_pkg::EXPO_MAX;
        hi_r   = aepid_pkg::EXPO_MAX;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: zero gains, full exposure range
        add_frame(16'h8000, 24'h000000);
        add_frame(16'h0000, 24'h000000);
        add_frame(16'hFFFF, 24'h000000);
        add_frame(16'h0000, aepid_pkg::EXPO_MAX);
        add_frame(16'hFFFF, aepid_pkg::EXPO_MAX);
        add_frame(16'h8000, aepid_pkg::EXPO_MAX);
        add_frame(16'h7FFF, 24'h123456);
        drain();

        // P gain 1/256, bounds inside the range: saturation at both limits, zero error
        load_settings('{16'h4000, 24'h010000, 24'h000100, 24'hFF8000,
                        24'd1000, 24'd2000000, 24'd1500000});
        write_reg(REG_UNUSED, 24'hA5A5A5);
        add_frame(16'h5000, 24'd1000);
        add_frame(16'h5000, 24'd999);
        add_frame(16'h3000, 24'd1000);
        add_frame(16'h3000, 24'd2000000);
        add_frame(16'h3000, 24'd2500000);
        add_frame(16'h5000, 24'd2000000);
        add_frame(16'h4000, 24'd1800000);
        add_frame(16'h4000, 24'd500);
        add_frame(16'h0000, 24'd1200000);
        add_frame(16'hFFFF, 24'd1200000);
        drain();

        // Floor above ceiling
        load_settings('{16'h8000, 24'h000800, 24'h000000, 24'h7FFFFF,
                        24'd5000, 24'd10000, 24'd3000});
        add_frame(16'h8000, 24'd4000);
        add_frame(16'h9000, 24'd6000);
        add_frame(16'h7000, 24'd6000);
        add_frame(16'h7000, 24'd12000);
        add_frame(16'h9000, 24'd4000);
        drain();

        run_random_phases(RANDOM_PHASES_PRE);
        run_random_phases(RANDOM_PHASES_POST);
        drain();

        $display("Checked %0d frames under %0d register settings, %0d results on a bound",
                 frames_in, settings_loaded, bound_hits);
        $display("%0d results compared, %0d mismatches", results_out, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
